>>> hdl/mesm_pkg.sv
// ----------------------------------------------------------------------------
// mesm_pkg
// shared widths, codes and transaction types of the moving edge match select
// ----------------------------------------------------------------------------
package mesm_pkg;

    // field widths
    localparam int RESP_W  = 25;   // raw response, q16.8 signed
    localparam int MASK_W  = 8;    // mask index
    localparam int STR_W   = 24;   // stored strength, q16.8
    localparam int CONV_W  = 26;   // sign-corrected response
    localparam int SCORE_W = 26;   // best score
    localparam int THR_W   = 25;   // likelihood threshold
    localparam int RATIO_W = 16;   // strength ratio, q4.12
    localparam int FRAC_W  = 12;   // fraction bits of the ratio
    localparam int GRAD_W  = 48;   // squared response, q32.16
    localparam int RANK_W  = 6;
    localparam int OUTC_W  = 2;

    // configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int REG_W  = 2;
    localparam logic [REG_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [REG_W-1:0] REG_RATIO_LOW  = 2'd1;
    localparam logic [REG_W-1:0] REG_RATIO_HIGH = 2'd2;

    localparam logic [THR_W-1:0]   THRESHOLD_RESET  = 25'd2560;
    localparam logic [RATIO_W-1:0] RATIO_LOW_RESET  = 16'd2048;
    localparam logic [RATIO_W-1:0] RATIO_HIGH_RESET = 16'd6144;

    // mask index jump that flips the contrast sign
    localparam logic [MASK_W-1:0] MASK_JUMP = 8'd120;
    // ratio of one in q4.12
    localparam logic [RATIO_W-1:0] Q_ONE = 16'd4096;

    // outcome codes
    localparam logic [OUTC_W-1:0] OUTCOME_MATCH     = 2'd0;
    localparam logic [OUTC_W-1:0] OUTCOME_CONTRAST  = 2'd1;
    localparam logic [OUTC_W-1:0] OUTCOME_THRESHOLD = 2'd2;

    typedef struct packed {
        logic signed [RESP_W-1:0] raw_response;
        logic [MASK_W-1:0]        mask_idx;
        logic [STR_W-1:0]         prev_strength;
        logic                     prev_negative;
        logic [MASK_W-1:0]        prev_mask_idx;
        logic                     contrast_test;
        logic                     last_candidate;
    } t_item;

    typedef struct packed {
        logic [OUTC_W-1:0] outcome;
        logic [RANK_W-1:0] best_rank;
        logic [STR_W-1:0]  new_strength;
        logic              new_negative;
        logic [MASK_W-1:0] new_mask_idx;
        logic [GRAD_W-1:0] gradient_norm;
    } t_result;

endpackage

>>> hdl/mesm_div.sv
// ----------------------------------------------------------------------------
// mesm_div
// bit-serial restoring divider for the q4.12 strength ratio, saturating
// ----------------------------------------------------------------------------
module mesm_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [mesm_pkg::RESP_W-1:0]         i_num,
    input  logic [mesm_pkg::STR_W-1:0]          i_den,
    output logic                                o_done,
    output logic [mesm_pkg::RATIO_W-1:0]        o_quot
);
    localparam int RATIO_W = mesm_pkg::RATIO_W;
    localparam int STR_W   = mesm_pkg::STR_W;
    localparam int RESP_W  = mesm_pkg::RESP_W;
    localparam int FRAC_W  = mesm_pkg::FRAC_W;
    localparam int SAT_SH  = RATIO_W - FRAC_W;          // integer bits of the ratio
    localparam int CNT_W   = $clog2(RATIO_W);
    localparam int HEAD_W  = RESP_W - SAT_SH;           // dividend bits above the window

    logic               r_busy;
    logic               r_done;
    logic               r_sat;
    logic [CNT_W-1:0]   r_cnt;
    logic [STR_W-1:0]   r_rem;
    logic [STR_W-1:0]   r_den;
    logic [RATIO_W-1:0] r_bits;
    logic [RATIO_W-1:0] r_quot;

    logic [STR_W-1:0]   head;
    logic [STR_W:0]     trial;
    logic [STR_W:0]     diff;
    logic               fits;

    assign head  = {{(STR_W-HEAD_W){1'b0}}, i_num[RESP_W-1:SAT_SH]};
    assign trial = {r_rem, r_bits[RATIO_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_den  <= i_den;
                r_rem  <= head;
                r_sat  <= (head >= i_den);
                r_bits <= {i_num[SAT_SH-1:0], {FRAC_W{1'b0}}};
                r_quot <= '0;
            end else if (r_busy) begin
                // one quotient bit a cycle
                r_rem  <= fits ? diff[STR_W-1:0] : trial[STR_W-1:0];
                r_quot <= {r_quot[RATIO_W-2:0], fits};
                r_bits <= {r_bits[RATIO_W-2:0], 1'b0};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(RATIO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? {RATIO_W{1'b1}} : r_quot;

endmodule

>>> hdl/mesm_sqr.sv
// ----------------------------------------------------------------------------
// mesm_sqr
// bit-serial shift-add squarer for the gradient norm
// ----------------------------------------------------------------------------
module mesm_sqr (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mesm_pkg::STR_W-1:0]    i_mag,
    output logic                          o_done,
    output logic [mesm_pkg::GRAD_W-1:0]   o_square
);
    localparam int STR_W = mesm_pkg::STR_W;
    localparam int CNT_W = $clog2(STR_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [STR_W-1:0] r_m;
    logic [STR_W:0]   r_hi;
    logic [STR_W-1:0] r_lo;

    logic [STR_W:0]   sum;

    assign sum = r_hi + (r_lo[0] ? {1'b0, r_m} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_m    <= i_mag;
                r_hi   <= '0;
                r_lo   <= i_mag;
            end else if (r_busy) begin
                // add on the low multiplier bit, then shift the pair right
                r_hi  <= {1'b0, sum[STR_W:1]};
                r_lo  <= {sum[0], r_lo[STR_W-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_square = {r_hi[STR_W-1:0], r_lo};

endmodule

>>> hdl/moving_edge_match_select.sv
// ----------------------------------------------------------------------------
// moving_edge_match_select
// keeps the best candidate along one edge site's normal and reports a match,
// a contrast suppression or a threshold suppression on the last candidate
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ----------------------------
//  item      in         i_valid / o_ready      i_item   (mesm_pkg::t_item)
//  result    out        o_valid / i_ready      o_result (mesm_pkg::t_result)
//  config    in         psel/penable/pwrite    paddr, pwdata, prdata, pready
//
//  one item at a time: o_ready is high only while the sequencer is idle
//  contrast item with a ratio to test: waits for the bit-serial divider
//  (one quotient bit per cycle, 16 bits); other items skip the divider
//  last candidate with a match also waits for the bit-serial squarer
//  the result sits in an output register; a stalled consumer only holds the
//  sequencer when the next result is ready before the previous one is taken
//  synchronous active-low reset clears the run and loads register defaults
//
module moving_edge_match_select #(
    parameter int MAX_QUERIES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item transaction
    input  logic                          i_valid,
    output logic                          o_ready,
    input  mesm_pkg::t_item               i_item,
    // result transaction
    output logic                          o_valid,
    input  logic                          i_ready,
    output mesm_pkg::t_result             o_result,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mesm_pkg::ADDR_W-1:0]   paddr,
    input  logic [mesm_pkg::DATA_W-1:0]   pwdata,
    output logic [mesm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    localparam int RESP_W  = mesm_pkg::RESP_W;
    localparam int MASK_W  = mesm_pkg::MASK_W;
    localparam int STR_W   = mesm_pkg::STR_W;
    localparam int CONV_W  = mesm_pkg::CONV_W;
    localparam int SCORE_W = mesm_pkg::SCORE_W;
    localparam int THR_W   = mesm_pkg::THR_W;
    localparam int RATIO_W = mesm_pkg::RATIO_W;
    localparam int GRAD_W  = mesm_pkg::GRAD_W;
    localparam int RANK_W  = mesm_pkg::RANK_W;
    localparam int DATA_W  = mesm_pkg::DATA_W;
    localparam int REG_W   = mesm_pkg::REG_W;
    localparam int CNT_W   = $clog2(MAX_QUERIES + 1);   // holds the cap itself
    localparam int POS_W   = $clog2(MAX_QUERIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_WRAP,
        S_SQR,
        S_FIN
    } t_state;

    t_state r_state;

    // configuration registers
    logic [THR_W-1:0]   r_thr;
    logic [RATIO_W-1:0] r_rlo;
    logic [RATIO_W-1:0] r_rhi;

    // latched item
    logic signed [CONV_W-1:0] r_conv;
    logic [STR_W-1:0]         r_prev;
    logic [MASK_W-1:0]        r_mi;
    logic [MASK_W-1:0]        r_pmi;
    logic                     r_ct;
    logic                     r_last;
    logic                     r_active;
    logic [POS_W-1:0]         r_pos;

    // run state
    logic [CNT_W-1:0]         r_count;
    logic                     r_wneg;
    logic                     r_best_found;
    logic [POS_W-1:0]         r_best_pos;
    logic [CONV_W-1:0]        r_best_resp;
    logic [SCORE_W-1:0]       r_best_score;
    logic                     r_ratio_seen;
    logic                     r_sq_sat;

    // output register
    logic                     r_out_valid;
    mesm_pkg::t_result        r_result;

    logic                     accept;
    logic                     cfg_write;
    logic [REG_W-1:0]         reg_sel;
    logic [MASK_W-1:0]        mask_diff;
    logic                     mask_jump;
    logic                     wneg_eff;
    logic [CONV_W-1:0]        raw_ext;
    logic [CONV_W-1:0]        conv_in;
    logic [CONV_W:0]          lik_sum;
    logic                     lik_pass;
    logic                     conv_pos;
    logic [CONV_W-1:0]        mag_conv;
    logic [CONV_W-1:0]        mag_best;
    logic [CONV_W-1:0]        plain_lik;
    logic                     plain_pass;
    logic                     div_start;
    logic                     div_done;
    logic [RATIO_W-1:0]       div_quot;
    logic [RATIO_W-1:0]       ratio_dist;
    logic                     ratio_pass;
    logic                     sqr_start;
    logic                     sqr_done;
    logic [GRAD_W-1:0]        sqr_square;
    mesm_pkg::t_result        fin_result;

    // ------------------------------------------------------------------
    // configuration port, zero wait states
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_sel   = paddr[mesm_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_sel)
            mesm_pkg::REG_THRESHOLD:  prdata = {{(DATA_W-THR_W){1'b0}}, r_thr};
            mesm_pkg::REG_RATIO_LOW:  prdata = {{(DATA_W-RATIO_W){1'b0}}, r_rlo};
            mesm_pkg::REG_RATIO_HIGH: prdata = {{(DATA_W-RATIO_W){1'b0}}, r_rhi};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= mesm_pkg::THRESHOLD_RESET;
            r_rlo <= mesm_pkg::RATIO_LOW_RESET;
            r_rhi <= mesm_pkg::RATIO_HIGH_RESET;
        end else if (cfg_write) begin
            case (reg_sel)
                mesm_pkg::REG_THRESHOLD:  r_thr <= pwdata[THR_W-1:0];
                mesm_pkg::REG_RATIO_LOW:  r_rlo <= pwdata[RATIO_W-1:0];
                mesm_pkg::REG_RATIO_HIGH: r_rhi <= pwdata[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // item intake: working sign and sign-corrected response
    // ------------------------------------------------------------------
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    assign mask_diff = (i_item.mask_idx >= i_item.prev_mask_idx)
                     ? i_item.mask_idx - i_item.prev_mask_idx
                     : i_item.prev_mask_idx - i_item.mask_idx;
    // a large mask jump means the edge turned around: flip the sign
    assign mask_jump = i_item.contrast_test && (mask_diff > mesm_pkg::MASK_JUMP);
    // sign is latched on the first candidate of the run
    assign wneg_eff  = (r_count == '0) ? (i_item.prev_negative ^ mask_jump) : r_wneg;
    assign raw_ext   = {i_item.raw_response[RESP_W-1], i_item.raw_response};
    assign conv_in   = wneg_eff ? (~raw_ext + 1'b1) : raw_ext;

    // ------------------------------------------------------------------
    // candidate tests
    // ------------------------------------------------------------------
    // likelihood = response + previous strength, signed compare
    assign lik_sum  = {r_conv[CONV_W-1], r_conv} + {{(CONV_W+1-STR_W){1'b0}}, r_prev};
    assign lik_pass = $signed(lik_sum) > $signed({{(CONV_W+1-THR_W){1'b0}}, r_thr});
    assign conv_pos = !r_conv[CONV_W-1] && (r_conv != '0);

    assign mag_conv = r_conv[CONV_W-1] ? (~r_conv + 1'b1) : r_conv;
    assign mag_best = r_best_resp[CONV_W-1] ? (~r_best_resp + 1'b1) : r_best_resp;

    // plain mode: twice the magnitude over threshold, and strictly above best
    assign plain_lik  = {mag_conv[CONV_W-2:0], 1'b0};
    assign plain_pass = (plain_lik > {{(CONV_W-THR_W){1'b0}}, r_thr})
                     && (!r_best_found || (mag_conv > mag_best));

    // ratio window and distance from one
    assign ratio_dist = (div_quot >= mesm_pkg::Q_ONE) ? div_quot - mesm_pkg::Q_ONE
                                                      : mesm_pkg::Q_ONE - div_quot;
    assign ratio_pass = (div_quot > r_rlo) && (div_quot < r_rhi)
                     && (!r_best_found
                         || ({{(SCORE_W-RATIO_W){1'b0}}, ratio_dist} < r_best_score));

    assign div_start = (r_state == S_EVAL) && r_active && r_ct && lik_pass
                    && conv_pos && (r_prev != '0);
    assign sqr_start = (r_state == S_WRAP) && r_last && r_best_found;

    mesm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_conv[RESP_W-1:0]),
        .i_den   (r_prev),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    mesm_sqr u_sqr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (sqr_start),
        .i_mag    (mag_best[STR_W-1:0]),
        .o_done   (sqr_done),
        .o_square (sqr_square)
    );

    // ------------------------------------------------------------------
    // result of the run
    // ------------------------------------------------------------------
    always_comb begin
        if (r_best_found) begin
            fin_result.outcome        = mesm_pkg::OUTCOME_MATCH;
            fin_result.best_rank      = RANK_W'(r_best_pos);
            // a magnitude of exactly 2^24 saturates the stored strength
            fin_result.new_strength   = mag_best[STR_W] ? {STR_W{1'b1}}
                                                        : mag_best[STR_W-1:0];
            fin_result.new_negative   = r_wneg ^ r_best_resp[CONV_W-1];
            fin_result.new_mask_idx   = r_mi;
            fin_result.gradient_norm  = r_sq_sat ? {GRAD_W{1'b1}} : sqr_square;
        end else begin
            fin_result.outcome        = (r_ct && r_ratio_seen)
                                      ? mesm_pkg::OUTCOME_CONTRAST
                                      : mesm_pkg::OUTCOME_THRESHOLD;
            fin_result.best_rank      = '0;
            fin_result.new_strength   = r_prev;
            fin_result.new_negative   = r_wneg;
            fin_result.new_mask_idx   = r_pmi;
            fin_result.gradient_norm  = '0;
        end
    end

    // ------------------------------------------------------------------
    // sequencer, run state and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_wneg       <= 1'b0;
            r_best_found <= 1'b0;
            r_best_pos   <= '0;
            r_best_resp  <= '0;
            r_best_score <= '0;
            r_ratio_seen <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // consumer takes the pending result
            if (r_out_valid && i_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_conv   <= conv_in;
                        r_prev   <= i_item.prev_strength;
                        r_mi     <= i_item.mask_idx;
                        r_pmi    <= i_item.prev_mask_idx;
                        r_ct     <= i_item.contrast_test;
                        r_last   <= i_item.last_candidate;
                        r_wneg   <= wneg_eff;
                        r_pos    <= r_count[POS_W-1:0];
                        // candidates past the cap only close the run
                        r_active <= (r_count < CNT_W'(MAX_QUERIES));
                        if (r_count < CNT_W'(MAX_QUERIES)) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_WRAP;
                    end
                    if (r_active) begin
                        if (r_ct) begin
                            if (lik_pass) begin
                                r_ratio_seen <= (r_conv != '0);
                            end
                        end else if (plain_pass) begin
                            r_best_found <= 1'b1;
                            r_best_score <= plain_lik;
                            r_best_resp  <= r_conv;
                            r_best_pos   <= r_pos;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (ratio_pass) begin
                            r_best_found <= 1'b1;
                            r_best_score <= {{(SCORE_W-RATIO_W){1'b0}}, ratio_dist};
                            r_best_resp  <= r_conv;
                            r_best_pos   <= r_pos;
                        end
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (sqr_start) begin
                        r_sq_sat <= mag_best[STR_W];
                        r_state  <= S_SQR;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_SQR: begin
                    if (sqr_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_ready) begin
                        r_result     <= fin_result;
                        r_out_valid  <= 1'b1;
                        // clear the run for the next site
                        r_count      <= '0;
                        r_wneg       <= 1'b0;
                        r_best_found <= 1'b0;
                        r_best_pos   <= '0;
                        r_best_resp  <= '0;
                        r_best_score <= '0;
                        r_ratio_seen <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule
